[design/timed_message_queue_core_assert.svh]
// Assertion macros used by the timed message queue core.
`ifndef TIMED_MESSAGE_QUEUE_CORE_ASSERT_SVH
`define TIMED_MESSAGE_QUEUE_CORE_ASSERT_SVH

// Checks that the consequent holds whenever the antecedent does.
`define TMQ_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition never occurs.
`define TMQ_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[design/tmq_pkg.sv]
// Types and codes of the timed message queue.
package tmq_pkg;

    localparam int DATA_W = 112;

    localparam logic [2:0] CMD_ADD         = 3'd0;
    localparam logic [2:0] CMD_ADD_TIMEOUT = 3'd1;
    localparam logic [2:0] CMD_DELETE      = 3'd2;
    localparam logic [2:0] CMD_KEEP_ALIVE  = 3'd3;
    localparam logic [2:0] CMD_TICK        = 3'd4;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ID   = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [17:0] {
        S_CLR      = 18'b000000000000000001,
        S_IDLE     = 18'b000000000000000010,
        S_A_NEXT   = 18'b000000000000000100,
        S_WALK_RD  = 18'b000000000000001000,
        S_WALK_CHK = 18'b000000000000010000,
        S_LNK_RD   = 18'b000000000000100000,
        S_LNK_WR1  = 18'b000000000001000000,
        S_LNK_WR2  = 18'b000000000010000000,
        S_U_CHK    = 18'b000000000100000000,
        S_U_FIN    = 18'b000000001000000000,
        S_T_RD     = 18'b000000010000000000,
        S_T_CHK    = 18'b000000100000000000,
        S_T_END    = 18'b000001000000000000,
        S_WAIT_RD  = 18'b000010000000000000,
        S_WAIT_CK  = 18'b000100000000000000,
        S_ACK      = 18'b001000000000000000,
        S_X_RD     = 18'b010000000000000000,
        S_X_EM     = 18'b100000000000000000
    } state_t;

endpackage

[design/tmq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/timed_message_queue_core.sv]
// Top level of the timed message queue: sorted timer list kept in RAMs.
//
//  Channel  | Direction | Handshake            | Contents
//  ---------+-----------+----------------------+----------------------------------------
//  in       | input     | in_valid / in_stall  | command, delay, target_id, handles, words
//  out      | output    | out_valid / out_stall| kind, status, entry_id, stored fields, wait
//  cfg      | input     | cfg_write            | keep_alive_ticks
//
// One request is handled at a time. Add and keep-alive take longer for every entry the
// sorted insert walks back over from the tail; a tick takes longer for every expired
// entry, both in the due scan and in the emission. The walks are set by the one read
// port of each state RAM. After reset a clearing pass over every slot builds the free
// list; in_stall is high during it. A stalled output holds its result while the next
// request may already be taken once the final result of the previous one sits in the
// output register.
module timed_message_queue_core
    import tmq_pkg::*;
#(
    parameter int POOL_DEPTH = 16,
    parameter int TIME_WIDTH = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    command,
    input  logic [31:0]                   delay,
    input  logic [$clog2(POOL_DEPTH)-1:0] target_id,
    input  logic [15:0]                   dest_handle,
    input  logic [15:0]                   msg_handle,
    input  logic [15:0]                   reply_handle,
    input  logic [31:0]                   ticket,
    input  logic [31:0]                   payload,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic [1:0]                    status,
    output logic [$clog2(POOL_DEPTH)-1:0] entry_id,
    output logic [15:0]                   out_dest,
    output logic [15:0]                   out_msg,
    output logic [15:0]                   out_reply,
    output logic [31:0]                   out_ticket,
    output logic [31:0]                   out_payload,
    output logic [31:0]                   wait_ticks,
    output logic                          queue_empty,
    output logic                          last
);

    `include "timed_message_queue_core_assert.svh"

    localparam int IDW = $clog2(POOL_DEPTH);
    localparam int TW  = TIME_WIDTH;
    localparam logic [IDW-1:0] LAST_ID = IDW'(POOL_DEPTH - 1);

    // Saturating time addition: the result never wraps past the all-ones time.
    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] base,
                                              input logic [TW-1:0] d);
        logic [TW:0] s;
        s = {1'b0, base} + {1'b0, d};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    // Control state.
    state_t           state_reg, state_next;
    logic [TW-1:0]    now_reg, now_next;
    logic [IDW-1:0]   head_reg, head_next;
    logic [IDW-1:0]   tail_reg, tail_next;
    logic [IDW-1:0]   free_reg, free_next;
    logic [31:0]      ka_reg, ka_next;
    logic [IDW-1:0]   clr_reg, clr_next;
    logic             ovalid_reg, ovalid_next;

    // Work registers of the request being handled.
    logic [IDW-1:0]   id_reg, id_next;
    logic [IDW-1:0]   w_reg, w_next;
    logic [IDW-1:0]   n_reg, n_next;
    logic [IDW-1:0]   h2_reg, h2_next;
    logic [IDW-1:0]   e_reg, e_next;
    logic [TW-1:0]    t_reg, t_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [1:0]       pkind_reg, pkind_next;
    logic [1:0]       pstat_reg, pstat_next;
    logic [IDW-1:0]   pid_reg, pid_next;
    logic [31:0]      wait_reg, wait_next;
    logic             empty_reg, empty_next;

    // Output register payload.
    logic [1:0]        okind_reg, okind_next;
    logic [1:0]        ostat_reg, ostat_next;
    logic [IDW-1:0]    oid_reg, oid_next;
    logic [DATA_W-1:0] odata_reg, odata_next;
    logic [31:0]       owait_reg, owait_next;
    logic              oempty_reg, oempty_next;
    logic              olast_reg, olast_next;

    // RAM ports.
    logic             nx_we, nx_re, pv_we, pv_re, lv_we, lv_re, du_we, du_re, da_we, da_re;
    logic [IDW-1:0]   nx_wa, nx_ra, pv_wa, pv_ra, lv_wa, lv_ra, du_wa, du_ra, da_wa, da_ra;
    logic [IDW-1:0]   nx_wd, nx_rd, pv_wd, pv_rd;
    logic             lv_wd, lv_rd;
    logic [TW-1:0]    du_wd, du_rd;
    logic [DATA_W-1:0] da_wd, da_rd;

    logic             slot_free;
    logic [TW:0]      diff;
    logic [15:0]      reply_sel;
    logic [31:0]      payload_sel;

    tmq_ram #(.WIDTH(IDW), .DEPTH(POOL_DEPTH)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
        .re(nx_re), .raddr(nx_ra), .rdata(nx_rd)
    );
    tmq_ram #(.WIDTH(IDW), .DEPTH(POOL_DEPTH)) u_prev_ram (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
        .re(pv_re), .raddr(pv_ra), .rdata(pv_rd)
    );
    tmq_ram #(.WIDTH(1), .DEPTH(POOL_DEPTH)) u_live_ram (
        .clk(clk), .we(lv_we), .waddr(lv_wa), .wdata(lv_wd),
        .re(lv_re), .raddr(lv_ra), .rdata(lv_rd)
    );
    tmq_ram #(.WIDTH(TW), .DEPTH(POOL_DEPTH)) u_due_ram (
        .clk(clk), .we(du_we), .waddr(du_wa), .wdata(du_wd),
        .re(du_re), .raddr(du_ra), .rdata(du_rd)
    );
    tmq_ram #(.WIDTH(DATA_W), .DEPTH(POOL_DEPTH)) u_data_ram (
        .clk(clk), .we(da_we), .waddr(da_wa), .wdata(da_wd),
        .re(da_re), .raddr(da_ra), .rdata(da_rd)
    );

    assign slot_free   = !ovalid_reg || !out_stall;
    assign diff        = {1'b0, du_rd} - {1'b0, now_reg};
    // Add with timeout stores a zero reply and puts the entry id in the payload word.
    assign reply_sel   = (command == CMD_ADD_TIMEOUT) ? 16'd0 : reply_handle;
    assign payload_sel = (command == CMD_ADD_TIMEOUT) ? 32'(free_reg) : payload;

    always_comb
    begin
        state_next  = state_reg;
        now_next    = now_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        ka_next     = cfg_write ? cfg_wdata : ka_reg;
        clr_next    = clr_reg;
        id_next     = id_reg;
        w_next      = w_reg;
        n_next      = n_reg;
        h2_next     = h2_reg;
        e_next      = e_reg;
        t_next      = t_reg;
        cmd_next    = cmd_reg;
        pkind_next  = pkind_reg;
        pstat_next  = pstat_reg;
        pid_next    = pid_reg;
        wait_next   = wait_reg;
        empty_next  = empty_reg;
        ovalid_next = (ovalid_reg && out_stall);
        okind_next  = okind_reg;
        ostat_next  = ostat_reg;
        oid_next    = oid_reg;
        odata_next  = odata_reg;
        owait_next  = owait_reg;
        oempty_next = oempty_reg;
        olast_next  = olast_reg;

        nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_re = 1'b0; nx_ra = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_re = 1'b0; pv_ra = '0;
        lv_we = 1'b0; lv_wa = '0; lv_wd = 1'b0; lv_re = 1'b0; lv_ra = '0;
        du_we = 1'b0; du_wa = '0; du_wd = '0; du_re = 1'b0; du_ra = '0;
        da_we = 1'b0; da_wa = '0; da_wd = '0; da_re = 1'b0; da_ra = '0;

        case (state_reg)
            S_CLR:
            begin
                // Slot 0 is never used; slots 1 to the last form the initial free list.
                nx_we = 1'b1;
                nx_wa = clr_reg;
                nx_wd = (clr_reg != '0 && clr_reg != LAST_ID) ? clr_reg + 1'b1 : '0;
                pv_we = 1'b1;
                pv_wa = clr_reg;
                lv_we = 1'b1;
                lv_wa = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ID)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    pkind_next = KIND_ACK;
                    pstat_next = ST_OK;
                    pid_next   = '0;
                    state_next = S_WAIT_RD;
                    case (command)
                        CMD_ADD, CMD_ADD_TIMEOUT:
                        begin
                            if (free_reg == '0)
                            begin
                                pstat_next = ST_FULL;
                            end
                            else
                            begin
                                id_next = free_reg;
                                t_next  = sat_add(now_reg, TW'(delay));
                                du_we = 1'b1;
                                du_wa = free_reg;
                                du_wd = sat_add(now_reg, TW'(delay));
                                da_we = 1'b1;
                                da_wa = free_reg;
                                da_wd = {payload_sel, ticket, reply_sel, msg_handle,
                                         dest_handle};
                                lv_we = 1'b1;
                                lv_wa = free_reg;
                                lv_wd = 1'b1;
                                nx_re = 1'b1;
                                nx_ra = free_reg;
                                state_next = S_A_NEXT;
                            end
                        end
                        CMD_DELETE, CMD_KEEP_ALIVE:
                        begin
                            if (target_id == '0 || 32'(target_id) >= 32'(POOL_DEPTH))
                            begin
                                pstat_next = ST_BAD_ID;
                            end
                            else
                            begin
                                id_next = target_id;
                                lv_re = 1'b1;
                                lv_ra = target_id;
                                pv_re = 1'b1;
                                pv_ra = target_id;
                                nx_re = 1'b1;
                                nx_ra = target_id;
                                state_next = S_U_CHK;
                            end
                        end
                        CMD_TICK:
                        begin
                            now_next   = sat_add(now_reg, TW'(1));
                            w_next     = head_reg;
                            e_next     = head_reg;
                            state_next = S_T_RD;
                        end
                        default:
                        begin
                            state_next = S_WAIT_RD;
                        end
                    endcase
                end
            end
            S_A_NEXT:
            begin
                free_next  = nx_rd;
                w_next     = tail_reg;
                state_next = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                if (w_reg == '0)
                begin
                    state_next = S_LNK_RD;
                end
                else
                begin
                    du_re = 1'b1;
                    du_ra = w_reg;
                    pv_re = 1'b1;
                    pv_ra = w_reg;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                // Walk back while the visited entry is due strictly later.
                if (du_rd > t_reg)
                begin
                    w_next = pv_rd;
                    if (pv_rd == '0)
                    begin
                        state_next = S_LNK_RD;
                    end
                    else
                    begin
                        du_re = 1'b1;
                        du_ra = pv_rd;
                        pv_re = 1'b1;
                        pv_ra = pv_rd;
                    end
                end
                else
                begin
                    state_next = S_LNK_RD;
                end
            end
            S_LNK_RD:
            begin
                nx_re = (w_reg != '0);
                nx_ra = w_reg;
                state_next = S_LNK_WR1;
            end
            S_LNK_WR1:
            begin
                pv_we = 1'b1;
                pv_wa = id_reg;
                pv_wd = w_reg;
                if (w_reg == '0)
                begin
                    n_next    = head_reg;
                    head_next = id_reg;
                end
                else
                begin
                    n_next = nx_rd;
                    nx_we  = 1'b1;
                    nx_wa  = w_reg;
                    nx_wd  = id_reg;
                end
                state_next = S_LNK_WR2;
            end
            S_LNK_WR2:
            begin
                nx_we = 1'b1;
                nx_wa = id_reg;
                nx_wd = n_reg;
                if (n_reg == '0)
                begin
                    tail_next = id_reg;
                end
                else
                begin
                    pv_we = 1'b1;
                    pv_wa = n_reg;
                    pv_wd = id_reg;
                end
                pid_next   = id_reg;
                state_next = S_WAIT_RD;
            end
            S_U_CHK:
            begin
                if (!lv_rd)
                begin
                    pstat_next = ST_INACTIVE;
                    state_next = S_WAIT_RD;
                end
                else
                begin
                    if (pv_rd != '0)
                    begin
                        nx_we = 1'b1;
                        nx_wa = pv_rd;
                        nx_wd = nx_rd;
                    end
                    else
                    begin
                        head_next = nx_rd;
                    end
                    if (nx_rd != '0)
                    begin
                        pv_we = 1'b1;
                        pv_wa = nx_rd;
                        pv_wd = pv_rd;
                    end
                    else
                    begin
                        tail_next = pv_rd;
                    end
                    state_next = S_U_FIN;
                end
            end
            S_U_FIN:
            begin
                if (cmd_reg == CMD_DELETE)
                begin
                    lv_we = 1'b1;
                    lv_wa = id_reg;
                    lv_wd = 1'b0;
                    nx_we = 1'b1;
                    nx_wa = id_reg;
                    nx_wd = free_reg;
                    free_next  = id_reg;
                    pid_next   = id_reg;
                    state_next = S_WAIT_RD;
                end
                else
                begin
                    t_next = sat_add(now_reg, TW'(ka_reg));
                    du_we  = 1'b1;
                    du_wa  = id_reg;
                    du_wd  = sat_add(now_reg, TW'(ka_reg));
                    w_next = tail_reg;
                    state_next = S_WALK_RD;
                end
            end
            S_T_RD:
            begin
                if (w_reg == '0)
                begin
                    state_next = S_T_END;
                end
                else
                begin
                    du_re = 1'b1;
                    du_ra = w_reg;
                    nx_re = 1'b1;
                    nx_ra = w_reg;
                    state_next = S_T_CHK;
                end
            end
            S_T_CHK:
            begin
                // Scan the due prefix of the list to find the head left after expiry.
                if (du_rd <= now_reg)
                begin
                    w_next = nx_rd;
                    if (nx_rd == '0)
                    begin
                        state_next = S_T_END;
                    end
                    else
                    begin
                        du_re = 1'b1;
                        du_ra = nx_rd;
                        nx_re = 1'b1;
                        nx_ra = nx_rd;
                    end
                end
                else
                begin
                    state_next = S_T_END;
                end
            end
            S_T_END:
            begin
                head_next = w_reg;
                h2_next   = w_reg;
                if (w_reg == '0)
                begin
                    tail_next = '0;
                end
                else
                begin
                    pv_we = 1'b1;
                    pv_wa = w_reg;
                    pv_wd = '0;
                end
                if (w_reg == e_reg)
                begin
                    pkind_next = KIND_NONE;
                end
                state_next = S_WAIT_RD;
            end
            S_WAIT_RD:
            begin
                du_re = (head_reg != '0);
                du_ra = head_reg;
                state_next = S_WAIT_CK;
            end
            S_WAIT_CK:
            begin
                if (head_reg == '0)
                begin
                    empty_next = 1'b1;
                    wait_next  = '1;
                end
                else
                begin
                    empty_next = 1'b0;
                    if (du_rd <= now_reg)
                    begin
                        wait_next = '0;
                    end
                    else if (diff > (TW+1)'(33'h0_FFFF_FFFF))
                    begin
                        wait_next = '1;
                    end
                    else
                    begin
                        wait_next = diff[31:0];
                    end
                end
                if (cmd_reg == CMD_TICK && e_reg != h2_reg)
                begin
                    w_next     = e_reg;
                    state_next = S_X_RD;
                end
                else
                begin
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = pkind_reg;
                    ostat_next  = pstat_reg;
                    oid_next    = pid_reg;
                    odata_next  = '0;
                    owait_next  = wait_reg;
                    oempty_next = empty_reg;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_X_RD:
            begin
                da_re = 1'b1;
                da_ra = w_reg;
                nx_re = 1'b1;
                nx_ra = w_reg;
                state_next = S_X_EM;
            end
            S_X_EM:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_EXPIRED;
                    ostat_next  = ST_OK;
                    oid_next    = w_reg;
                    odata_next  = da_rd;
                    owait_next  = wait_reg;
                    oempty_next = empty_reg;
                    olast_next  = (nx_rd == h2_reg);
                    lv_we = 1'b1;
                    lv_wa = w_reg;
                    lv_wd = 1'b0;
                    nx_we = 1'b1;
                    nx_wa = w_reg;
                    nx_wd = free_reg;
                    free_next = w_reg;
                    w_next    = nx_rd;
                    state_next = (nx_rd == h2_reg) ? S_IDLE : S_X_RD;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            now_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            free_reg   <= IDW'(1);
            ka_reg     <= 32'd30000;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            now_reg    <= now_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            free_reg   <= free_next;
            ka_reg     <= ka_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        w_reg      <= w_next;
        n_reg      <= n_next;
        h2_reg     <= h2_next;
        e_reg      <= e_next;
        t_reg      <= t_next;
        cmd_reg    <= cmd_next;
        pkind_reg  <= pkind_next;
        pstat_reg  <= pstat_next;
        pid_reg    <= pid_next;
        wait_reg   <= wait_next;
        empty_reg  <= empty_next;
        okind_reg  <= okind_next;
        ostat_reg  <= ostat_next;
        oid_reg    <= oid_next;
        odata_reg  <= odata_next;
        owait_reg  <= owait_next;
        oempty_reg <= oempty_next;
        olast_reg  <= olast_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ovalid_reg;
    assign kind        = okind_reg;
    assign status      = ostat_reg;
    assign entry_id    = oid_reg;
    assign out_dest    = odata_reg[15:0];
    assign out_msg     = odata_reg[31:16];
    assign out_reply   = odata_reg[47:32];
    assign out_ticket  = odata_reg[79:48];
    assign out_payload = odata_reg[111:80];
    assign wait_ticks  = owait_reg;
    assign queue_empty = oempty_reg;
    assign last        = olast_reg;

    // A live head entry can never also sit at the top of the free list.
    `TMQ_ASSERT_IMPLY(a_head_not_free, head_reg != '0, free_reg != head_reg, "head is on free list")
    // An empty queue always reports the all-ones wait.
    `TMQ_ASSERT_IMPLY(a_empty_wait, ovalid_reg && oempty_reg, owait_reg == '1, "empty wait not saturated")
    // An expired entry result always names a real slot.
    `TMQ_ASSERT_NEVER(a_expired_id, ovalid_reg && okind_reg == KIND_EXPIRED && oid_reg == '0, "expired id zero")

endmodule
